// ===== rtl/core/mspfr_pkg.sv =====
`timescale 1ns / 1ps

package mspfr_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned RSP_DATA_W  = 40;

   localparam logic [BYTE_W-1:0] SYNC_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] SYNC_M      = 8'h4D;
   localparam logic [BYTE_W-1:0] SYNC_REPLY  = 8'h3E;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // One result as it leaves the parser.
   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] index;
      logic [BYTE_W-1:0] command;
      logic [BYTE_W-1:0] length;
      logic              good;
   } rsp_item_type;

endpackage

// ===== rtl/core/msp_frame_receiver.sv =====
`timescale 1ns / 1ps

// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+--------------------------------------
// request   | in        | req_tvalid/req_tready | tdata[7:0] rx_byte
// response  | out       | rsp_tvalid/rsp_tready | tdata: payload_byte, payload_index,
//           |           |                       | frame_command, frame_length,
//           |           |                       | checksum_good; tuser: result_kind
//
// One request is taken per cycle while the input register's byte can move on. A byte is
// decoded by the parser while it sits in the input register, and any result it yields
// is then registered in the output register, from which the response is offered.
// The synchronous reset returns the parser to hunting for the start byte.
// Header bytes never stall; payload and checksum bytes wait in the input register
// while the output register holds a response that has not been taken.

module msp_frame_receiver
   import mspfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,   // [7:0] rx_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_command,
   // [31:24] frame_length, [32] checksum_good, [39:33] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser    // [0] result_kind
);

   logic              item_valid;
   logic [BYTE_W-1:0] item_byte;
   logic              has_result;
   logic              out_free;
   logic              advance;
   rsp_item_type      result;

   // A byte moves on when it yields nothing, or when the output register has room.
   assign advance = item_valid && (!has_result || out_free);

   mspfr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   mspfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .advance    (advance),
      .has_result (has_result),
      .result     (result)
   );

   mspfr_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && has_result),
      .item       (result),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/mspfr_in_stage.sv =====
`timescale 1ns / 1ps

module mspfr_in_stage
   import mspfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [BYTE_W-1:0] req_tdata,
   input  logic              advance,
   output logic              item_valid,
   output logic [BYTE_W-1:0] item_byte
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;

   // The register may refill in the same cycle that its byte moves on.
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// ===== rtl/core/mspfr_parser.sv =====
`timescale 1ns / 1ps

module mspfr_parser
   import mspfr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  logic [BYTE_W-1:0] item_byte,
   input  logic              advance,
   output logic              has_result,
   output rsp_item_type      result
);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_DOLLAR = 3'd1,
      PH_M      = 3'd2,
      PH_ARROW  = 3'd3,
      PH_SIZE   = 3'd4,
      PH_BODY   = 3'd5
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0] offset_ff, offset_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] command_ff, command_in;
   logic              in_payload;

   assign in_payload = offset_ff < length_ff;
   assign has_result = item_valid && (phase_ff == PH_BODY);

   always_comb begin
      result.kind    = in_payload ? KIND_PAYLOAD : KIND_END;
      result.data    = in_payload ? item_byte : '0;
      result.index   = offset_ff;
      result.command = command_ff;
      result.length  = length_ff;
      result.good    = !in_payload && (xor_ff == item_byte);
   end

   always_comb begin
      phase_in   = phase_ff;
      length_in  = length_ff;
      offset_in  = offset_ff;
      xor_in     = xor_ff;
      command_in = command_ff;
      case (phase_ff)
         PH_DOLLAR: begin
            phase_in = (item_byte == SYNC_M) ? PH_M : PH_IDLE;
         end
         PH_M: begin
            phase_in = (item_byte == SYNC_REPLY) ? PH_ARROW : PH_IDLE;
         end
         PH_ARROW: begin
            length_in = item_byte;
            offset_in = '0;
            xor_in    = item_byte;
            phase_in  = PH_SIZE;
         end
         PH_SIZE: begin
            command_in = item_byte;
            xor_in     = xor_ff ^ item_byte;
            phase_in   = PH_BODY;
         end
         PH_BODY: begin
            if (in_payload) begin
               xor_in    = xor_ff ^ item_byte;
               offset_in = offset_ff + 1'b1;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            // Idle, and any code that cannot arise, hunts for the start byte.
            phase_in = (item_byte == SYNC_DOLLAR) ? PH_DOLLAR : PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         length_ff  <= '0;
         offset_ff  <= '0;
         xor_ff     <= '0;
         command_ff <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         length_ff  <= length_in;
         offset_ff  <= offset_in;
         xor_ff     <= xor_in;
         command_ff <= command_in;
      end
   end

endmodule

// ===== rtl/core/mspfr_out_stage.sv =====
`timescale 1ns / 1ps

module mspfr_out_stage
   import mspfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  rsp_item_type          item,
   output logic                  free,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   logic         valid_ff, valid_in;
   rsp_item_type item_ff, item_in;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      item_in  = item_ff;
      if (load) begin
         valid_in = 1'b1;
         item_in  = item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = item_ff.kind;
   assign rsp_tdata  = {7'b0, item_ff.good, item_ff.length, item_ff.command,
                        item_ff.index, item_ff.data};

endmodule
